>>> rtl/segmented_frame_transmitter_core_assert.svh
// Assertion macros shared by the segmented frame transmitter modules.
// The clocked forms use the module's clk_i; SFT_ASSERT also uses rst_ni.
`ifndef SEGMENTED_FRAME_TRANSMITTER_CORE_ASSERT_SVH
`define SEGMENTED_FRAME_TRANSMITTER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SFT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SFT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SFT_ASSERT(lbl, prop, msg)
`define SFT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> rtl/sft_pkg.sv
package sft_pkg;

  localparam int unsigned FRAME_BYTES = 8;
  localparam int unsigned POS_W       = $clog2(FRAME_BYTES);
  localparam int unsigned LEN_W       = 12;
  localparam int unsigned SF_MAX_DATA = FRAME_BYTES - 1;

  localparam logic [3:0] PCI_TYPE_FIRST  = 4'h1;
  localparam logic [3:0] PCI_TYPE_CONSEC = 4'h2;
  localparam logic [7:0] PAD_RESET       = 8'hFF;

  typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

  // One classified item handed from the front to the back.
  typedef struct packed {
    logic [7:0]       data;
    logic [POS_W-1:0] pos;
    logic             hdr0_we;
    logic [7:0]       hdr0;
    logic             hdr1_we;
    logic [7:0]       hdr1;
    logic             emit;
    logic             done;
  } op_t;

endpackage

>>> rtl/sft_front.sv
`include "segmented_frame_transmitter_core_assert.svh"

module sft_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  output logic                             ready_o,
  input  logic [7:0]                       payload_byte_i,
  input  logic [sft_pkg::LEN_W-1:0]        message_length_i,
  output logic                             push_o,
  output sft_pkg::op_t                     op_o,
  input  logic                             full_i
);

  logic [sft_pkg::LEN_W-1:0] rem_q, rem_d;
  logic [sft_pkg::POS_W-1:0] pos_q, pos_d;
  logic [3:0]                seq_q, seq_d;

  logic                      start;
  logic                      long_msg;
  logic                      accept;
  logic [sft_pkg::LEN_W-1:0] len;
  logic [sft_pkg::LEN_W-1:0] rem_cur;
  logic [sft_pkg::LEN_W-1:0] rem_next;
  logic [sft_pkg::POS_W-1:0] pos_cur;

  assign ready_o = !full_i;
  assign accept  = valid_i && ready_o;
  assign push_o  = accept;

  always_comb begin
    start    = (rem_q == '0);
    len      = (message_length_i == '0) ? sft_pkg::LEN_W'(1) : message_length_i;
    long_msg = (len > sft_pkg::LEN_W'(sft_pkg::SF_MAX_DATA));
    rem_cur  = start ? len : rem_q;
    pos_cur  = start ? (long_msg ? sft_pkg::POS_W'(2) : sft_pkg::POS_W'(1)) : pos_q;
    rem_next = rem_cur - sft_pkg::LEN_W'(1);

    op_o.data    = payload_byte_i;
    op_o.pos     = pos_cur;
    op_o.done    = (rem_next == '0);
    op_o.emit    = op_o.done || (pos_cur == sft_pkg::POS_W'(sft_pkg::FRAME_BYTES - 1));
    op_o.hdr0_we = start || (pos_q == sft_pkg::POS_W'(1));
    if (start) begin
      op_o.hdr0 = long_msg ? {sft_pkg::PCI_TYPE_FIRST, len[11:8]} : len[7:0];
    end else begin
      op_o.hdr0 = {sft_pkg::PCI_TYPE_CONSEC, seq_q};
    end
    op_o.hdr1_we = start && long_msg;
    op_o.hdr1    = len[7:0];
  end

  always_comb begin
    rem_d = rem_q;
    pos_d = pos_q;
    seq_d = seq_q;
    if (accept) begin
      rem_d = rem_next;
      seq_d = start ? 4'd0 : seq_q;
      if (op_o.emit) begin
        if (op_o.done) begin
          pos_d = '0;
        end else begin
          pos_d = sft_pkg::POS_W'(1);
          seq_d = seq_d + 4'd1;
        end
      end else begin
        pos_d = pos_cur + sft_pkg::POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      pos_q <= '0;
      seq_q <= '0;
    end else begin
      rem_q <= rem_d;
      pos_q <= pos_d;
      seq_q <= seq_d;
    end
  end

  `SFT_ASSERT(a_done_ends_msg, accept && op_o.done |=> rem_q == '0,
              "message not closed after final frame")
  `SFT_ASSERT(a_start_has_hdr, accept && start |-> op_o.hdr0_we,
              "message start without header byte")
  `SFT_ASSERT(a_emit_next_pos, accept && op_o.emit && !op_o.done |=> pos_q == 1,
              "consecutive frame does not restart at position one")

endmodule

>>> rtl/sft_queue.sv
`include "segmented_frame_transmitter_core_assert.svh"

module sft_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  sft_pkg::op_t op_i,
  output logic         full_o,
  output logic         valid_o,
  output sft_pkg::op_t op_o,
  input  logic         pop_i
);

  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  sft_pkg::op_t      entries_q [DEPTH];
  logic [ADDR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [ADDR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign op_o    = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + ADDR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == ADDR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + ADDR_W'(1);
    end
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  `SFT_ASSERT(a_count_bound, count_q <= CNT_W'(DEPTH), "queue count beyond depth")
  `SFT_ASSERT(a_pop_nonempty, pop_i |-> valid_o, "pop from empty queue")
  `SFT_ASSERT(a_push_not_full, push_i |-> !full_o, "push into full queue")

endmodule

>>> rtl/sft_back.sv
module sft_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  sft_pkg::op_t        op_i,
  output logic                pop_o,
  input  logic [7:0]          padding_byte_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sft_pkg::frame_t     out_frame_o,
  output logic                out_done_o
);

  sft_pkg::frame_t store_q;
  sft_pkg::frame_t merged;
  sft_pkg::frame_t padded;
  sft_pkg::frame_t out_frame_q;
  logic            out_done_q;
  logic            out_valid_q, out_valid_d;
  logic            out_free;
  logic            load;

  assign out_free = !out_valid_q || out_ready_i;
  assign pop_o    = valid_i && (!op_i.emit || out_free);
  assign load     = pop_o && op_i.emit;

  always_comb begin
    for (int unsigned i = 0; i < sft_pkg::FRAME_BYTES; i++) begin
      if (sft_pkg::POS_W'(i) == op_i.pos) begin
        merged[i] = op_i.data;
      end else if (i == 0 && op_i.hdr0_we) begin
        merged[i] = op_i.hdr0;
      end else if (i == 1 && op_i.hdr1_we) begin
        merged[i] = op_i.hdr1;
      end else begin
        merged[i] = store_q[i];
      end
      padded[i] = (sft_pkg::POS_W'(i) > op_i.pos) ? padding_byte_i : merged[i];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      store_q <= merged;
    end
    if (load) begin
      out_frame_q <= padded;
      out_done_q  <= op_i.done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_frame_o = out_frame_q;
  assign out_done_o  = out_done_q;

endmodule

>>> rtl/segmented_frame_transmitter_core.sv
// Channel       | Direction | Contents
// s_axis        | in        | tdata: payload_byte [7:0], message_length [19:8]
// m_axis        | out       | tdata: frame bytes 0..7; tlast: message_done
// padding_byte  | config    | write enable and 8-bit padding value
//
// One payload byte is taken per cycle while the queue is not full; a frame
// is sent through the item queue and the output register after its last byte.
// Reset clears the message counters, queue and output valid; padding is 0xFF.
// A stalled output holds the frame and the queue fills behind it; input is
// refused only when the queue is full.
module segmented_frame_transmitter_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // payload_byte, message_length, zero fill
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,  // frame_byte_0 up to frame_byte_7
  output logic        m_axis_tlast_o,
  input  logic        padding_byte_we_i,
  input  logic [7:0]  padding_byte_i
);

  logic [7:0]      padding_q;
  logic            push;
  logic            full;
  logic            q_valid;
  logic            pop;
  sft_pkg::op_t    front_op;
  sft_pkg::op_t    back_op;
  sft_pkg::frame_t frame;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      padding_q <= sft_pkg::PAD_RESET;
    end else if (padding_byte_we_i) begin
      padding_q <= padding_byte_i;
    end
  end

  sft_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (s_axis_tvalid_i),
    .ready_o          (s_axis_tready_o),
    .payload_byte_i   (s_axis_tdata_i[7:0]),
    .message_length_i (s_axis_tdata_i[19:8]),
    .push_o           (push),
    .op_o             (front_op),
    .full_i           (full)
  );

  sft_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (front_op),
    .full_o  (full),
    .valid_o (q_valid),
    .op_o    (back_op),
    .pop_i   (pop)
  );

  sft_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (q_valid),
    .op_i           (back_op),
    .pop_o          (pop),
    .padding_byte_i (padding_q),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .out_frame_o    (frame),
    .out_done_o     (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = frame;

endmodule
